[hdl/ttm_pkg.sv]
// Shared types and constants for the tap tempo median BPM block.
// Used by ttm_median, ttm_div and tap_tempo_median_bpm; depends on nothing.
package ttm_pkg;

  localparam int IV_W           = 16;
  localparam int TIME_W         = 32;
  localparam int KEY_W          = 7;
  localparam int BPM_W          = 23;
  localparam int NUM_W          = 24;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int HIST_DEPTH_DEF = 7;

  // 60000 ms per minute in Q8, and the largest tempo that is reported.
  localparam logic [NUM_W-1:0] BPM_NUM   = 24'd15360000;
  localparam logic [BPM_W-1:0] BPM_LIMIT = 23'd7680000;

  localparam logic [IV_W-1:0]  MIN_IV_RST   = 16'd100;
  localparam logic [IV_W-1:0]  MAX_IV_RST   = 16'd5000;
  localparam logic [KEY_W-1:0] BEAT_KEY_RST = 7'd41;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_IV,
    REG_MAX_IV,
    REG_BEAT_KEY,
    REG_BLOB_KEY
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MED,
    S_DIV,
    S_HOLD
  } ctl_state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_id;
    logic              beat_held;
    logic              blob_held;
    logic [TIME_W-1:0] time_ms;
  } in_word_t;

  typedef struct packed {
    logic             bpm_updated;
    logic [BPM_W-1:0] bpm_q8;
    logic             blob_trigger;
  } out_word_t;

  typedef struct packed {
    logic push;
    logic start;
  } med_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } med_stat_t;

  // Interval history after reset, oldest entry first.
  function automatic logic [IV_W-1:0] hist_reset(int unsigned idx);
    logic [IV_W-1:0] v;
    unique case (idx)
      0:       v = 16'd900;
      1:       v = 16'd1200;
      2:       v = 16'd1100;
      3:       v = 16'd1000;
      4:       v = 16'd1400;
      default: v = 16'd1000;
    endcase
    return v;
  endfunction

endpackage

[hdl/ttm_median.sv]
// Interval history with a bit-serial median select, one bit per cycle, MSB first.
// Depends on ttm_pkg.
module ttm_median import ttm_pkg::*; #(
  parameter int Depth = HIST_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  med_ctrl_t       ctrl,
  input  logic [IV_W-1:0] push_value,
  output med_stat_t       stat,
  output logic [IV_W-1:0] median
);

  localparam int CntW = $clog2(Depth + 1);
  localparam int BitW = $clog2(IV_W);
  localparam int Mid  = Depth / 2;

  logic [IV_W-1:0]  hist [Depth];
  logic [Depth-1:0] cand;
  logic [Depth-1:0] msb;
  logic [Depth-1:0] ones;
  logic [CntW-1:0]  rank;
  logic [CntW-1:0]  n_ones;
  logic [BitW-1:0]  bit_cnt;
  logic             busy;
  logic             done;
  logic             take_one;

  // Radix select: rank counts how many still-candidate entries sit above the
  // median in descending order. If more candidates than that have a one at
  // this bit, the median has a one here too.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      msb[i] = hist[i][IV_W-1];
    end
    ones     = cand & msb;
    n_ones   = CntW'($countones(ones));
    take_one = n_ones > rank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Depth; i++) begin
        hist[i] <= hist_reset(unsigned'(i));
      end
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        // A full rotation through all IV_W bits leaves the history as it was.
        for (int i = 0; i < Depth; i++) begin
          hist[i] <= {hist[i][IV_W-2:0], hist[i][IV_W-1]};
        end
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == BitW'(IV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else begin
        if (ctrl.push) begin
          for (int i = 0; i < Depth - 1; i++) begin
            hist[i] <= hist[i+1];
          end
          hist[Depth-1] <= push_value;
        end
        if (ctrl.start) begin
          busy    <= 1'b1;
          bit_cnt <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      cand   <= take_one ? ones : (cand & ~msb);
      rank   <= take_one ? rank : (rank - n_ones);
      median <= {median[IV_W-2:0], take_one};
    end else if (ctrl.start) begin
      cand <= '1;
      rank <= CntW'(Mid);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[hdl/ttm_div.sv]
// Bit-serial restoring divider for the constant tempo numerator over the median.
// Depends on ttm_pkg.
module ttm_div import ttm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [IV_W-1:0]  divisor,
  output logic             done,
  output logic [BPM_W-1:0] quotient
);

  localparam int CntW = $clog2(NUM_W);

  logic [NUM_W-1:0] num_sh;
  logic [NUM_W-1:0] quo;
  logic [IV_W-1:0]  rem;
  logic [IV_W-1:0]  dvs;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic             sat;
  logic [IV_W:0]    trial;
  logic [IV_W:0]    diff;
  logic             ge;

  always_comb begin
    trial = {rem, num_sh[NUM_W-1]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  // The remainder stays below the divisor, so it fits in IV_W bits.
  always_ff @(posedge clk) begin
    if (busy) begin
      rem    <= ge ? diff[IV_W-1:0] : trial[IV_W-1:0];
      quo    <= {quo[NUM_W-2:0], ge};
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
    end else if (start) begin
      rem    <= '0;
      quo    <= '0;
      num_sh <= BPM_NUM;
      dvs    <= divisor;
      // A divisor of zero or one lands at or above the limit.
      sat    <= (divisor[IV_W-1:1] == '0);
    end
  end

  assign quotient = sat ? BPM_LIMIT : quo[BPM_W-1:0];

endmodule

[hdl/tap_tempo_median_bpm.sv]
// Tap tempo estimator: median of recent tap intervals turned into BPM in Q8.
// Depends on ttm_pkg, ttm_median and ttm_div.
//
// Input words (in_valid/in_ready) are key change events; each one gives
// exactly one output word (out_valid/out_ready). A word whose beat key is
// not held returns at once with bpm_updated low and bpm_q8 zero: its result
// goes from the result register to the output register. Any other word
// runs the median select, one bit of the 16-bit intervals per cycle, then a
// restoring divide, one of 24 quotient bits per cycle. Its result then moves
// to the output register, and only then can the next word be taken; the two
// serial loops set how fast taps go through. The block works on one word at
// a time. The output register holds a finished word while the receiver
// stalls, and a new input word is still taken then; its result waits until
// the output register is free. The configuration port writes one register
// per cycle; the user must use it only while the block is idle, which the
// block does not enforce. Reset restores the default bounds and beat key,
// clears the last tap time and reloads the default interval history.
module tap_tempo_median_bpm import ttm_pkg::*; #(
  parameter int HistoryDepth = HIST_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_state_t        state;
  ctl_state_t        state_next;
  logic [IV_W-1:0]   min_iv;
  logic [IV_W-1:0]   max_iv;
  logic [KEY_W-1:0]  beat_key;
  logic [TIME_W-1:0] last_tap;
  out_word_t         res;
  logic              accept;
  logic              tap;
  logic              tap_ok;
  logic [TIME_W-1:0] delta;
  logic              out_load;
  med_ctrl_t         med_ctrl;
  med_stat_t         med_stat;
  logic [IV_W-1:0]   median;
  logic              div_start;
  logic              div_done;
  logic [BPM_W-1:0]  quotient;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign tap      = accept && in_data.beat_held && (in_data.key_id == beat_key);
  assign delta    = in_data.time_ms - last_tap;

  // A positive interval below max_iv has zero upper half.
  assign tap_ok = tap && (delta[TIME_W-1:IV_W] == '0)
                  && (delta[IV_W-1:0] > min_iv) && (delta[IV_W-1:0] < max_iv);

  assign med_ctrl.push  = tap_ok;
  assign med_ctrl.start = accept && in_data.beat_held;
  assign div_start      = (state == S_MED) && med_stat.done;
  assign out_load       = (state == S_HOLD) && (!out_valid || out_ready);

  ttm_median #(
    .Depth(HistoryDepth)
  ) u_median (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (med_ctrl),
    .push_value (delta[IV_W-1:0]),
    .stat       (med_stat),
    .median     (median)
  );

  ttm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (median),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = in_data.beat_held ? S_MED : S_HOLD;
        end
      end
      S_MED: begin
        if (med_stat.done) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_iv    <= MIN_IV_RST;
      max_iv    <= MAX_IV_RST;
      beat_key  <= BEAT_KEY_RST;
      last_tap  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_MIN_IV:   min_iv   <= cfg_data;
          REG_MAX_IV:   max_iv   <= cfg_data;
          REG_BEAT_KEY: beat_key <= cfg_data[KEY_W-1:0];
          // The blob level already arrives in blob_held, so its key id is
          // not needed here.
          REG_BLOB_KEY: ;
        endcase
      end
      if (tap) begin
        last_tap <= in_data.time_ms;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.bpm_updated  <= in_data.beat_held;
      res.bpm_q8       <= '0;
      res.blob_trigger <= in_data.blob_held;
    end else if (div_done) begin
      res.bpm_q8 <= quotient;
    end
    if (out_load) begin
      out_data <= res;
    end
  end

  a_med_in_med_state: assert property (@(posedge clk) disable iff (rst)
    med_stat.busy |-> state == S_MED)
    else $error("median select running outside its state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its state");

  a_bpm_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.bpm_q8 <= BPM_LIMIT)
    else $error("tempo above limit");

  a_early_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.bpm_updated |-> out_data.bpm_q8 == '0)
    else $error("early return word carries a tempo");

  a_no_med_start_busy: assert property (@(posedge clk) disable iff (rst)
    med_ctrl.start |-> !med_stat.busy && !div_done)
    else $error("new word started while previous one in progress");

endmodule

[sim/ttm_checker.sv]
// Checker for the tap tempo median BPM block: predicts each output word and compares it.
// Watches the event, result and register ports; depends on ttm_pkg.
module ttm_checker import ttm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_word_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    err_count,
  output int                    outstanding,
  output int                    taps_kept,
  output int                    ceiling_hits
);

  localparam int DEPTH = HIST_DEPTH_DEF;
  localparam logic [KEY_W-1:0] BLOB_KEY_START = 7'd40;
  // Oldest interval sits in the lowest slice.
  localparam logic [DEPTH*IV_W-1:0] HIST_START = {16'd1000, 16'd1000, 16'd1400, 16'd1000,
                                                  16'd1100, 16'd1200, 16'd900};

  logic [DEPTH-1:0][IV_W-1:0] hist;
  logic [TIME_W-1:0]          last_tap;
  logic [IV_W-1:0]            lo_bound;
  logic [IV_W-1:0]            hi_bound;
  logic [KEY_W-1:0]           beat_key_m;
  logic [KEY_W-1:0]           blob_key_m;
  out_word_t                  tempo_due[$];
  int                         errs = 0;
  int                         kept_n = 0;
  int                         ceil_n = 0;

  // Advances the tap history for one event and returns the tempo word it yields.
  function automatic out_word_t next_tempo(in_word_t w);
    out_word_t                  r;
    logic [TIME_W-1:0]          gap;
    logic [DEPTH-1:0][IV_W-1:0] sorted;
    logic [IV_W-1:0]            v;
    logic [IV_W-1:0]            med;
    logic [31:0]                q;
    int                         j;
    r = '0;
    r.blob_trigger = w.blob_held;
    if (!w.beat_held) return r;
    if (w.key_id == beat_key_m) begin
      gap = w.time_ms - last_tap;
      // The gap is a signed difference, so a set top bit means the tap went backward.
      if (!gap[TIME_W-1] && gap > 32'(lo_bound) && gap < 32'(hi_bound)) begin
        hist = {gap[IV_W-1:0], hist[DEPTH-1:1]};
        kept_n++;
      end
      last_tap = w.time_ms;
    end
    sorted = '0;
    for (int i = 0; i < DEPTH; i++) begin
      v = hist[i];
      j = i;
      while (j > 0 && sorted[j-1] < v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    med = sorted[DEPTH/2];
    if (med == 0) begin
      q = 32'(BPM_LIMIT);
    end else begin
      q = 32'(BPM_NUM) / 32'(med);
      if (q > 32'(BPM_LIMIT)) q = 32'(BPM_LIMIT);
    end
    if (q == 32'(BPM_LIMIT)) ceil_n++;
    r.bpm_updated = 1'b1;
    r.bpm_q8 = q[BPM_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst) begin
      hist       = HIST_START;
      last_tap   = '0;
      lo_bound   = MIN_IV_RST;
      hi_bound   = MAX_IV_RST;
      beat_key_m = BEAT_KEY_RST;
      blob_key_m = BLOB_KEY_START;
      tempo_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MIN_IV:   lo_bound   = cfg_data;
          REG_MAX_IV:   hi_bound   = cfg_data;
          REG_BEAT_KEY: beat_key_m = cfg_data[KEY_W-1:0];
          REG_BLOB_KEY: blob_key_m = cfg_data[KEY_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) tempo_due.push_back(next_tempo(in_data));
      if (out_valid && out_ready) begin
        if (tempo_due.size() == 0) begin
          $display("%0t: result word with no event pending, got %h", $time, out_data);
          errs++;
        end else begin
          want = tempo_due.pop_front();
          check_field("bpm_updated", 32'(want.bpm_updated), 32'(out_data.bpm_updated));
          check_field("bpm_q8", 32'(want.bpm_q8), 32'(out_data.bpm_q8));
          check_field("blob_trigger", 32'(want.blob_trigger), 32'(out_data.blob_trigger));
        end
      end
    end
    outstanding  <= tempo_due.size();
    err_count    <= errs;
    taps_kept    <= kept_n;
    ceiling_hits <= ceil_n;
  end

endmodule

[sim/testbench.sv]
// Top of the tap tempo median BPM testbench: clock, reset, event and register stimulus.
// Depends on ttm_pkg, tap_tempo_median_bpm and ttm_checker.
module testbench;
  import ttm_pkg::*;

  localparam int WATCH_LIMIT = 3000;
  localparam int TAIL_CYCLES = 50;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int waiting;
  int kept;
  int ceiling;
  int idle_cycles = 0;
  int sent = 0;
  int settings = 1;

  logic              steady = 1'b0;
  logic [IV_W-1:0]   cur_lo = MIN_IV_RST;
  logic [IV_W-1:0]   cur_hi = MAX_IV_RST;
  logic [KEY_W-1:0]  cur_beat = BEAT_KEY_RST;
  logic [TIME_W-1:0] tap_clock = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tap_tempo_median_bpm uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ttm_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .err_count    (mismatches),
    .outstanding  (waiting),
    .taps_kept    (kept),
    .ceiling_hits (ceiling)
  );

  // Mostly no gap or a short one, now and then a long one.
  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // Tap spacing: mostly inside the open bounds, some on the edges, some wild.
  function automatic logic [TIME_W-1:0] pick_interval(logic [IV_W-1:0] lo, logic [IV_W-1:0] hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75 && int'(hi) - int'(lo) >= 2) return $urandom_range(int'(hi) - 1, int'(lo) + 1);
    if (r < 88) begin
      case ($urandom_range(0, 3))
        0:       return 32'(lo);
        1:       return 32'(lo) + 1;
        2:       return 32'(hi) - 1;
        default: return 32'(hi);
      endcase
    end
    if (r < 96) return $urandom_range(0, 65535);
    return $urandom();
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic post_event(input logic [KEY_W-1:0] key, input logic beat, input logic blob,
                            input logic [TIME_W-1:0] t);
    in_word_t w;
    w.key_id    = key;
    w.beat_held = beat;
    w.blob_held = blob;
    w.time_ms   = t;
    if (beat && key == cur_beat) tap_clock = t;
    send_word(w);
  endtask

  // Holds the sender back until every result word has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic settle_regs(input logic [IV_W-1:0] lo, input logic [IV_W-1:0] hi,
                             input logic [KEY_W-1:0] beat, input logic [KEY_W-1:0] blob);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_write(REG_MIN_IV, lo);
    cfg_write(REG_MAX_IV, hi);
    // Key registers are narrower than the data bus; junk in the upper bits must be dropped.
    cfg_write(REG_BEAT_KEY, (16'($urandom) & 16'hFF80) | 16'(beat));
    cfg_write(REG_BLOB_KEY, (16'($urandom) & 16'hFF80) | 16'(blob));
    cfg_we   <= 1'b0;
    cur_lo   = lo;
    cur_hi   = hi;
    cur_beat = beat;
    settings++;
  endtask

  task automatic run_random(input int n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      steady = (i % 160) >= 130;
      if (i == n / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < 65)
        post_event(cur_beat, 1'b1, 1'($urandom), tap_clock + pick_interval(cur_lo, cur_hi));
      else if (r < 80)
        post_event(r < 72 ? cur_beat : 7'($urandom), 1'b0, 1'($urandom), $urandom());
      else if (r < 92)
        post_event(7'($urandom), 1'b1, 1'($urandom), $urandom());
      else
        post_event(cur_beat, 1'b1, 1'($urandom), $urandom());
    end
    steady = 1'b0;
  endtask

  initial begin : out_pacing
    int n;
    forever begin
      out_ready <= 1'b1;
      n = steady ? 1 : $urandom_range(1, 8);
      repeat (n) @(posedge clk);
      n = steady ? 0 : gap_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCH_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCH_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [TIME_W-1:0] t;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset bounds and keys: edges of the interval test and of the timestamp.
    post_event(BEAT_KEY_RST, 1'b0, 1'b1, 32'hFFFF_FFFF);
    post_event(BEAT_KEY_RST, 1'b1, 1'b0, 32'd0);
    post_event(BEAT_KEY_RST, 1'b1, 1'b1, 32'd100);
    post_event(BEAT_KEY_RST, 1'b1, 1'b0, 32'd201);
    post_event(BEAT_KEY_RST, 1'b1, 1'b0, 32'd5200);
    post_event(BEAT_KEY_RST, 1'b1, 1'b1, 32'd10200);
    post_event(BEAT_KEY_RST, 1'b1, 1'b0, 32'd10190);
    t = 32'd10190 + 32'h8000_0000;
    post_event(BEAT_KEY_RST, 1'b1, 1'b0, t);
    post_event(BEAT_KEY_RST, 1'b1, 1'b1, t + 32'h7FFF_FFFF);
    post_event(7'd0, 1'b1, 1'b1, 32'h5555_5555);
    post_event(7'd127, 1'b1, 1'b0, 32'hAAAA_AAAA);
    post_event(7'd127, 1'b0, 1'b1, 32'h0F0F_0F0F);
    post_event(7'd40, 1'b1, 1'b1, 32'hF0F0_F0F0);
    // A tap across the timestamp wrap still measures a short interval.
    post_event(BEAT_KEY_RST, 1'b1, 1'b0, 32'hFFFF_FF00);
    post_event(BEAT_KEY_RST, 1'b1, 1'b0, 32'h0000_0100);
    // Long taps pull the median up, then short ones pull it down.
    for (int i = 0; i < 4; i++) post_event(BEAT_KEY_RST, 1'b1, 1'b0, tap_clock + 32'd4999);
    for (int i = 0; i < 4; i++) post_event(BEAT_KEY_RST, 1'b1, 1'b1, tap_clock + 32'd101);

    run_random(400);
    // Zero lower bound lets one-millisecond taps in, driving the tempo to its ceiling.
    settle_regs(16'd0, 16'd3, 7'd0, 7'd127);
    run_random(250);
    settle_regs(16'd1, 16'd65535, 7'd127, 7'd0);
    run_random(250);
    // Crossed and closed bounds: no interval can be kept.
    settle_regs(16'd5000, 16'd100, 7'd41, 7'd40);
    run_random(150);
    settle_regs(16'd65535, 16'd65535, 7'd64, 7'd1);
    run_random(100);
    settle_regs(16'd1, 16'd2, 7'd1, 7'd127);
    run_random(100);
    settle_regs(16'd200, 16'd2000, 7'd41, 7'd40);
    run_random(500);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d key events under %0d register settings.", sent, settings);
    $display("%0d tap intervals entered the history; %0d tempo results hit the ceiling.",
             kept, ceiling);
    if (mismatches == 0 && waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/ttm_pkg.sv
hdl/ttm_median.sv
hdl/ttm_div.sv
hdl/tap_tempo_median_bpm.sv
sim/ttm_checker.sv
sim/testbench.sv
